// ===== hdl/vdrt_pkg.sv =====
`timescale 1ns / 1ps

package vdrt_pkg;

    // screen geometry and tile grid
    localparam int unsigned TILE_COLUMNS = 80;
    localparam int unsigned TILE_ROWS    = 50;
    localparam int unsigned TILE_COUNT   = TILE_COLUMNS * TILE_ROWS;
    localparam int unsigned TILE_AW      = $clog2(TILE_COUNT);
    localparam logic [9:0]  SCREEN_W     = 10'd640;
    localparam logic [8:0]  SCREEN_H     = 9'd400;

    // floor(n / 5) for n below 2048 as (n * RECIP_DIV5) >> RECIP_SHIFT
    localparam logic [11:0] RECIP_DIV5   = 12'd3277;
    localparam int unsigned RECIP_SHIFT  = 14;

    // operation codes
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_REDRAW = 3'd1;
    localparam logic [2:0] OP_DPAL   = 3'd2;
    localparam logic [2:0] OP_APAL   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_QUERY  = 3'd5;

    // screen modes
    localparam logic [1:0] MODE_DIG200  = 2'd0;
    localparam logic [1:0] MODE_DIG400  = 2'd1;
    localparam logic [1:0] MODE_4K      = 2'd2;
    localparam logic [1:0] MODE_256K    = 2'd3;

    // register port
    localparam int unsigned PADDR_W       = 3;
    localparam logic        REG_DISP_MODE = 1'b0;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] vram_address;
        logic [11:0] tile_index;
    } t_in_item;

    typedef struct packed {
        logic [8:0] box_top;
        logic [8:0] box_bottom;
        logic [9:0] box_left;
        logic [9:0] box_right;
        logic       palette_pending;
        logic       clear_pending;
        logic       tile_dirty;
    } t_out_item;

    // decoded item between the address split and the state update
    typedef struct packed {
        logic [2:0]         op;
        logic               on_screen;
        logic [9:0]         x;
        logic [8:0]         y;
        logic [8:0]         bottom_new;
        logic [9:0]         right_new;
        logic [TILE_AW-1:0] addr;
        logic               q_hit;
    } t_dec;

endpackage

// ===== hdl/vram_dirty_region_tracker.sv =====
`timescale 1ns / 1ps

// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+----------------------------
// event in  | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
// result    | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
// register  | input     | psel, penable, pready     | paddr, pwdata, prdata
//
// one item per cycle sustained while i_out_ready is high; each result goes through
// the input register, address split register, state and tile memory read register
// after reset the 4000-entry tile memory is cleared one entry per cycle,
// with o_in_ready low; register writes are taken throughout
// an output stall fills the empty stages first, then holds o_in_ready low

module vram_dirty_region_tracker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  vdrt_pkg::t_in_item                     i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output vdrt_pkg::t_out_item                    o_out_data,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [vdrt_pkg::PADDR_W-1:0]           paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int unsigned AW = vdrt_pkg::TILE_AW;

    logic [1:0]          r_mode;
    logic                r_clr_busy;
    logic [AW-1:0]       r_clr_cnt;
    logic                r_v1, r_v2, r_v3;
    vdrt_pkg::t_in_item  r_s1;
    vdrt_pkg::t_dec      r_s2;
    vdrt_pkg::t_out_item r_out;
    logic                r_q_hit, r_q_force, r_rd;
    logic [8:0]          r_top, r_bottom;
    logic [9:0]          r_left, r_right;
    logic                r_pal, r_clr, r_all_set;
    logic                r_tile_mem [0:vdrt_pkg::TILE_COUNT-1];

    logic                n_en1, n_en2, n_en3, n_step;
    vdrt_pkg::t_dec      n_dec;
    logic [14:0]         n_a, n_qm;
    logic [10:0]         n_num;
    logic [22:0]         n_prod;
    logic [8:0]          n_q;
    logic [9:0]          n_x, n_y;
    logic [5:0]          n_trow;
    logic [6:0]          n_tcol;
    logic [AW-1:0]       n_tile;
    logic [9:0]          n_bot_sum;
    logic [8:0]          n_top, n_bottom;
    logic [9:0]          n_left, n_right;
    logic                n_pal, n_clr, n_all_set;

    // pipeline flow control
    assign n_en3      = !r_v3 || i_out_ready;
    assign n_en2      = !r_v2 || n_en3;
    assign n_en1      = !r_v1 || n_en2;
    assign n_step     = n_en3 && r_v2;
    assign o_in_ready = n_en1 && !r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (n_en1) r_v1 <= i_in_valid && o_in_ready;
            if (n_en2) r_v2 <= r_v1;
            if (n_en3) r_v3 <= r_v2;
        end
    end

    // register port
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[2] == vdrt_pkg::REG_DISP_MODE) prdata = {30'd0, r_mode};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= vdrt_pkg::MODE_DIG200;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == vdrt_pkg::REG_DISP_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    // tile memory clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_cnt == AW'(vdrt_pkg::TILE_COUNT - 1)) r_clr_busy <= 1'b0;
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_s1 <= i_in_data;
    end

    // address split: masked address divided by 80 or 40 through a reciprocal of five
    always_comb begin
        n_a   = {1'b0, r_s1.vram_address[13:0]};
        n_num = n_a[14:4];
        unique case (r_mode)
            vdrt_pkg::MODE_DIG400: begin
                n_a   = r_s1.vram_address[14:0];
                n_num = n_a[14:4];
            end
            vdrt_pkg::MODE_DIG200: begin
                n_a   = {1'b0, r_s1.vram_address[13:0]};
                n_num = n_a[14:4];
            end
            vdrt_pkg::MODE_4K, vdrt_pkg::MODE_256K: begin
                n_a   = {2'b00, r_s1.vram_address[12:0]};
                n_num = {1'b0, n_a[12:3]};
            end
            default: begin
                n_a   = {1'b0, r_s1.vram_address[13:0]};
                n_num = n_a[14:4];
            end
        endcase

        n_prod = 23'(n_num) * 23'(vdrt_pkg::RECIP_DIV5);
        n_q    = n_prod[22:vdrt_pkg::RECIP_SHIFT];

        // quotient times 80 or 40, remainder scaled to a pixel column
        if (r_mode[1]) begin
            n_qm = {1'b0, n_q, 5'd0} + {3'd0, n_q, 3'd0};
            n_x  = {n_a[5:0] - n_qm[5:0], 4'd0};
            n_y  = {n_q, 1'b0};
        end else begin
            n_qm = {n_q, 6'd0} + {2'd0, n_q, 4'd0};
            n_x  = {n_a[6:0] - n_qm[6:0], 3'd0};
            n_y  = (r_mode == vdrt_pkg::MODE_DIG400) ? {1'b0, n_q} : {n_q, 1'b0};
        end

        // tile number row*80 + column
        n_trow = n_y[8:3];
        n_tcol = n_x[9:3];
        n_tile = {n_trow, 6'd0} + {2'd0, n_trow, 4'd0} + {5'd0, n_tcol};

        n_bot_sum = (r_mode == vdrt_pkg::MODE_DIG400) ? n_y + 10'd1 : n_y + 10'd2;

        n_dec            = '0;
        n_dec.op         = r_s1.operation;
        n_dec.on_screen  = (n_y < {1'b0, vdrt_pkg::SCREEN_H}) && (n_x < vdrt_pkg::SCREEN_W);
        n_dec.x          = n_x;
        n_dec.y          = n_y[8:0];
        n_dec.bottom_new = n_bot_sum[8:0];
        n_dec.right_new  = r_mode[1] ? n_x + 10'd16 : n_x + 10'd8;
        n_dec.q_hit      = (r_s1.operation == vdrt_pkg::OP_QUERY)
                           && (r_s1.tile_index < 12'(vdrt_pkg::TILE_COUNT));
        if (r_s1.operation == vdrt_pkg::OP_WRITE) n_dec.addr = n_tile;
        else if (n_dec.q_hit)                     n_dec.addr = r_s1.tile_index[AW-1:0];
        else                                      n_dec.addr = '0;
    end

    always_ff @(posedge i_clk) begin
        if (n_en2 && r_v1) r_s2 <= n_dec;
    end

    // state update for the item leaving the decode register
    always_comb begin
        n_top     = r_top;
        n_bottom  = r_bottom;
        n_left    = r_left;
        n_right   = r_right;
        n_pal     = r_pal;
        n_clr     = r_clr;
        n_all_set = r_all_set;
        unique case (r_s2.op)
            vdrt_pkg::OP_WRITE: begin
                if (r_s2.on_screen) begin
                    if (r_top > r_s2.y)     n_top    = r_s2.y;
                    if (r_bottom <= r_s2.y) n_bottom = r_s2.bottom_new;
                    if (r_left > r_s2.x)    n_left   = r_s2.x;
                    if (r_right <= r_s2.x)  n_right  = r_s2.right_new;
                end
            end
            vdrt_pkg::OP_REDRAW: begin
                n_top     = '0;
                n_bottom  = vdrt_pkg::SCREEN_H;
                n_left    = '0;
                n_right   = vdrt_pkg::SCREEN_W;
                n_pal     = 1'b1;
                n_clr     = 1'b1;
                n_all_set = 1'b1;
            end
            vdrt_pkg::OP_DPAL: begin
                n_pal = 1'b1;
            end
            vdrt_pkg::OP_APAL: begin
                n_pal     = 1'b1;
                n_top     = '0;
                n_left    = '0;
                n_all_set = 1'b1;
            end
            vdrt_pkg::OP_CLEAR: begin
                n_top     = '0;
                n_bottom  = vdrt_pkg::SCREEN_H;
                n_left    = '0;
                n_right   = vdrt_pkg::SCREEN_W;
                n_clr     = 1'b0;
                n_all_set = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= '0;
            r_bottom  <= vdrt_pkg::SCREEN_H;
            r_left    <= '0;
            r_right   <= vdrt_pkg::SCREEN_W;
            r_pal     <= 1'b0;
            r_clr     <= 1'b0;
            r_all_set <= 1'b0;
        end else if (n_step) begin
            r_top     <= n_top;
            r_bottom  <= n_bottom;
            r_left    <= n_left;
            r_right   <= n_right;
            r_pal     <= n_pal;
            r_clr     <= n_clr;
            r_all_set <= n_all_set;
        end
    end

    // tile flags: set per write, whole-screen sets kept in r_all_set
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_tile_mem[r_clr_cnt] <= 1'b0;
        end else if (n_step && r_s2.op == vdrt_pkg::OP_WRITE && r_s2.on_screen) begin
            r_tile_mem[r_s2.addr] <= 1'b1;
        end
        if (n_step) r_rd <= r_tile_mem[r_s2.addr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (n_step) begin
            r_out.box_top         <= n_top;
            r_out.box_bottom      <= n_bottom;
            r_out.box_left        <= n_left;
            r_out.box_right       <= n_right;
            r_out.palette_pending <= n_pal;
            r_out.clear_pending   <= n_clr;
            r_out.tile_dirty      <= 1'b0;
            r_q_hit               <= r_s2.q_hit;
            r_q_force             <= r_s2.q_hit && r_all_set;
        end
    end

    always_comb begin
        o_out_data            = r_out;
        o_out_data.tile_dirty = r_q_force || (r_q_hit && r_rd);
    end

    assign o_out_valid = r_v3;

`ifndef SYNTHESIS
    // box never inverted or beyond the screen
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_top < r_bottom) && (r_left < r_right)
        && (r_bottom <= vdrt_pkg::SCREEN_H) && (r_right <= vdrt_pkg::SCREEN_W))
        else $error("dirty box out of order");

    // no item in flight while the tile memory is being cleared
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_v1 && !r_v2 && !r_v3))
        else $error("item in flight during tile clear");

    // a pending clear always comes with a palette change
    a_clr_pal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> r_pal)
        else $error("clear pending without palette pending");

    // whole-screen tile set is sticky until reset
    a_all_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_all_set |=> r_all_set)
        else $error("all-tiles flag dropped");
`endif

endmodule
